>>> rtl/ffha_pkg.sv
// Shared types and codes for the first-fit heap allocator.
// No dependencies; used by the controller, datapath and top level.
package ffha_pkg;

  localparam int HEAP_BYTES = 2048;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_NO_FIT   = 2'd2,
    ST_DBL_FREE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,       // issue node read
    S_WAIT,     // read data lands
    S_EVAL,     // examine node
    S_SCAN_RD,  // slot map scan
    S_SCAN_EV,
    S_SPLIT,    // write split remainder
    S_SPLIT_WR, // write shrunk current node
    S_NXT_EV,
    S_PRV_EV,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;         // latch input word
    logic rd_cur;       // read node at cur
    logic ld_cur;       // capture node at cur
    logic rd_nxt;       // read node at cur.next
    logic rd_prv;       // read node at prev
    logic adv;          // step to next node
    logic scan_adv;
    logic wr_new;       // write split remainder
    logic wr_cur_alloc; // write current node as used
    logic split;
    logic free_cur;     // mark current node free
    logic wr_cur_free;  // write freed current node
    logic merge_nxt;
    logic merge_prv;
    logic set_qfree;
    logic set_result;
    logic [1:0] res_status;
  } ffha_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic bad_size;
    logic cur_valid;
    logic steps_out;
    logic cur_fits;
    logic cur_free;
    logic cur_holds;
    logic spare_nz;
    logic slot_free;
    logic scan_end;
    logic nxt_valid;
    logic nxt_free;
    logic prv_valid;
    logic prv_free;
  } ffha_sts_t;

endpackage

>>> rtl/ffha_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/ffha_ctrl.sv
// Controller state machine for the heap allocator.
// Depends on ffha_pkg; drives ffha_dp through command and status structs.
module ffha_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ffha_pkg::ffha_sts_t sts,
  output ffha_pkg::ffha_cmd_t cmd
);
  ffha_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ffha_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.res_status = ffha_pkg::ST_OK;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ffha_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ffha_pkg::S_RD;
        end
      end
      ffha_pkg::S_RD: begin
        if (sts.op == ffha_pkg::OP_ALLOC && sts.bad_size) begin
          cmd.set_result = 1'b1;
          cmd.res_status = ffha_pkg::ST_BAD_SIZE;
          state_next = ffha_pkg::S_DONE;
        end else if (!sts.cur_valid || sts.steps_out ||
                     sts.op == ffha_pkg::OP_NONE) begin
          cmd.set_result = 1'b1;
          cmd.res_status = (sts.op == ffha_pkg::OP_ALLOC) ? ffha_pkg::ST_NO_FIT
                                                          : ffha_pkg::ST_OK;
          state_next = ffha_pkg::S_DONE;
        end else begin
          cmd.rd_cur = 1'b1;
          state_next = ffha_pkg::S_WAIT;
        end
      end
      ffha_pkg::S_WAIT: begin
        cmd.ld_cur = 1'b1;
        state_next = ffha_pkg::S_EVAL;
      end
      ffha_pkg::S_EVAL: begin
        if (sts.op == ffha_pkg::OP_ALLOC) begin
          if (sts.cur_free && sts.cur_fits) begin
            if (sts.spare_nz) state_next = ffha_pkg::S_SCAN_RD;
            else begin
              cmd.wr_cur_alloc = 1'b1;
              cmd.set_result = 1'b1;
              state_next = ffha_pkg::S_DONE;
            end
          end else begin
            cmd.adv = 1'b1;
            state_next = ffha_pkg::S_RD;
          end
        end else if (sts.cur_holds) begin
          cmd.set_result = 1'b1;
          if (sts.op == ffha_pkg::OP_QUERY) begin
            cmd.set_qfree = 1'b1;
            state_next = ffha_pkg::S_DONE;
          end else if (sts.cur_free) begin
            cmd.res_status = ffha_pkg::ST_DBL_FREE;
            state_next = ffha_pkg::S_DONE;
          end else begin
            cmd.free_cur = 1'b1;
            cmd.rd_nxt = 1'b1;
            state_next = ffha_pkg::S_NXT_EV;
          end
        end else begin
          cmd.adv = 1'b1;
          state_next = ffha_pkg::S_RD;
        end
      end
      ffha_pkg::S_SCAN_RD: state_next = ffha_pkg::S_SCAN_EV;
      ffha_pkg::S_SCAN_EV: begin
        if (sts.slot_free) state_next = ffha_pkg::S_SPLIT;
        else if (sts.scan_end) begin
          cmd.wr_cur_alloc = 1'b1; // no spare slot: give whole block
          cmd.set_result = 1'b1;
          state_next = ffha_pkg::S_DONE;
        end else begin
          cmd.scan_adv = 1'b1;
          state_next = ffha_pkg::S_SCAN_RD;
        end
      end
      ffha_pkg::S_SPLIT: begin
        cmd.wr_new = 1'b1;
        state_next = ffha_pkg::S_SPLIT_WR;
      end
      ffha_pkg::S_SPLIT_WR: begin
        cmd.wr_cur_alloc = 1'b1;
        cmd.split = 1'b1;
        cmd.set_result = 1'b1;
        state_next = ffha_pkg::S_DONE;
      end
      ffha_pkg::S_NXT_EV: begin
        if (sts.nxt_valid && sts.nxt_free) cmd.merge_nxt = 1'b1;
        cmd.rd_prv = 1'b1;
        state_next = ffha_pkg::S_PRV_EV;
      end
      ffha_pkg::S_PRV_EV: begin
        if (sts.prv_valid && sts.prv_free) cmd.merge_prv = 1'b1;
        else cmd.wr_cur_free = 1'b1;
        state_next = ffha_pkg::S_DONE;
      end
      ffha_pkg::S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ffha_pkg::S_IDLE;
      end
      default: state_next = ffha_pkg::S_IDLE;
    endcase
  end
endmodule

>>> rtl/ffha_dp.sv
// Datapath: node table and slot map RAMs, chain walk registers, results.
// Depends on ffha_pkg and ffha_ram.
module ffha_dp (
  input  logic                clk,
  input  logic                rst,
  input  ffha_pkg::ffha_cmd_t cmd,
  output ffha_pkg::ffha_sts_t sts,
  output logic                clr_done,
  input  logic [1:0]          op,
  input  logic [11:0]         request_size,
  input  logic [10:0]         offset,
  output logic [1:0]          status,
  output logic [10:0]         block_offset,
  output logic                offset_free,
  output logic [11:0]         bytes_left
);
  localparam int HB = ffha_pkg::HEAP_BYTES;
  localparam int AW = $clog2(HB);
  localparam int LW = AW + 1;          // link width: holds null code
  localparam int SW = $clog2(HB + 1);
  localparam int NW = AW + SW + 1 + LW;
  localparam logic [LW-1:0] NIL = LW'(HB);

  typedef struct packed {
    logic [AW-1:0] start;
    logic [SW-1:0] size;
    logic          free;
    logic [LW-1:0] next;
  } node_t;

  // request
  logic [1:0]    r_op;
  logic [SW:0]   r_size;
  logic [AW:0]   r_off;
  logic [SW-1:0] remaining;
  // walk
  logic [LW-1:0] cur, prev;
  logic [LW:0]   steps;
  logic [AW-1:0] scan;
  logic          clearing;
  logic [AW-1:0] clr_idx;
  node_t         cur_n;
  node_t         nd_rd;
  logic [AW-1:0] ra_q;
  logic [SW-1:0] taken;
  logic [SW:0]   freed_sum;

  // node table
  logic          n_we;
  logic [AW-1:0] n_wa, n_ra;
  node_t         n_wd;
  ffha_ram #(.WIDTH(NW), .DEPTH(HB)) u_node (
    .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(nd_rd));

  // slot map
  logic          u_we, u_wd, u_rd;
  logic [AW-1:0] u_wa;
  ffha_ram #(.WIDTH(1), .DEPTH(HB)) u_slot (
    .clk(clk), .we(u_we), .waddr(u_wa), .wdata(u_wd), .raddr(scan), .rdata(u_rd));

  assign clr_done = !clearing;
  assign taken = cmd.split ? r_size[SW-1:0] : cur_n.size;
  assign freed_sum = (SW+1)'(remaining) + (SW+1)'(cur_n.size);

  always_comb begin
    // hold the read address so read data stays valid
    n_ra = ra_q;
    if (cmd.rd_cur) n_ra = cur[AW-1:0];
    if (cmd.rd_nxt) n_ra = cur_n.next[AW-1:0];
    if (cmd.rd_prv) n_ra = prev[AW-1:0];
    n_we = 1'b0; n_wa = cur[AW-1:0]; n_wd = cur_n;
    u_we = 1'b0; u_wa = scan; u_wd = 1'b0;
    if (clearing) begin
      u_we = 1'b1; u_wa = clr_idx; u_wd = (clr_idx == '0);
      n_we = (clr_idx == '0);
      n_wa = '0;
      n_wd = '{start: '0, size: SW'(HB), free: 1'b1, next: NIL};
    end else begin
      if (cmd.wr_new) begin
        n_we = 1'b1; n_wa = scan;
        n_wd = '{start: AW'(cur_n.start + r_size[SW-1:0]),
                 size: SW'(cur_n.size - r_size[SW-1:0]), free: 1'b1,
                 next: cur_n.next};
        u_we = 1'b1; u_wa = scan; u_wd = 1'b1;
      end
      if (cmd.wr_cur_alloc) begin
        n_we = 1'b1; n_wa = cur[AW-1:0];
        n_wd = '{start: cur_n.start, size: taken, free: 1'b0,
                 next: cmd.split ? LW'(scan) : cur_n.next};
      end
      if (cmd.wr_cur_free) begin
        n_we = 1'b1; n_wa = cur[AW-1:0]; n_wd = cur_n;
      end
      if (cmd.merge_nxt) begin
        u_we = 1'b1; u_wa = cur_n.next[AW-1:0];
      end
      if (cmd.merge_prv) begin
        n_we = 1'b1; n_wa = prev[AW-1:0];
        n_wd = '{start: nd_rd.start, size: SW'(nd_rd.size + cur_n.size), free: 1'b1,
                 next: cur_n.next};
        u_we = 1'b1; u_wa = cur[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx <= '0;
      remaining <= SW'(HB);
      ra_q <= '0;
      r_op <= ffha_pkg::OP_NONE;
      r_size <= '0;
      r_off <= '0;
      cur <= '0; prev <= NIL; steps <= '0; scan <= '0;
      cur_n <= '0;
      status <= ffha_pkg::ST_OK; block_offset <= '0; offset_free <= 1'b0;
    end else begin
      ra_q <= n_ra;
      if (clearing) begin
        if (clr_idx == AW'(HB - 1)) clearing <= 1'b0;
        clr_idx <= clr_idx + 1'b1;
      end
      if (cmd.load) begin
        r_op <= op;
        r_size <= (SW+1)'(request_size);
        r_off <= (AW+1)'(offset);
        cur <= '0; prev <= NIL; steps <= '0; scan <= '0;
        status <= ffha_pkg::ST_OK; block_offset <= '0; offset_free <= 1'b0;
      end
      if (cmd.rd_cur) steps <= steps + 1'b1;
      if (cmd.ld_cur) cur_n <= nd_rd;
      if (cmd.adv) begin
        prev <= cur; cur <= cur_n.next;
      end
      if (cmd.scan_adv) scan <= scan + 1'b1;
      if (cmd.set_result) status <= cmd.res_status;
      if (cmd.set_qfree) offset_free <= cur_n.free;
      if (cmd.wr_cur_alloc) begin
        remaining <= (taken <= remaining) ? remaining - taken : '0;
        block_offset <= 11'(cur_n.start);
      end
      if (cmd.free_cur) begin
        cur_n.free <= 1'b1;
        remaining <= (freed_sum > (SW+1)'(HB)) ? SW'(HB) : freed_sum[SW-1:0];
      end
      if (cmd.merge_nxt) begin
        cur_n.size <= SW'(cur_n.size + nd_rd.size);
        cur_n.next <= nd_rd.next;
      end
    end
  end

  always_comb begin
    sts = '0;
    sts.op = r_op;
    sts.bad_size = (r_size == '0) || (r_size > (SW+1)'(remaining));
    sts.cur_valid = (cur < NIL);
    sts.steps_out = (steps >= (LW+1)'(HB));
    sts.cur_fits = (SW+1)'(cur_n.size) >= r_size;
    sts.cur_free = cur_n.free;
    sts.cur_holds = ((AW+1)'(cur_n.start) <= r_off) &&
                    ((SW+1)'(r_off - (AW+1)'(cur_n.start)) < (SW+1)'(cur_n.size));
    sts.spare_nz = (SW+1)'(cur_n.size) != r_size;
    sts.slot_free = !u_rd;
    sts.scan_end = (scan == AW'(HB - 1));
    sts.nxt_valid = cur_n.next < NIL;
    sts.nxt_free = nd_rd.free;
    sts.prv_valid = prev < NIL;
    sts.prv_free = nd_rd.free;
  end

  assign bytes_left = 12'(remaining);
endmodule

>>> rtl/first_fit_heap_allocator.sv
// First-fit heap allocator: one result word per request word.
// A bad size or unused op is answered without a walk; else chain nodes are read in turn until
// one matches or the chain ends. A query, double free or exact fit ends at its node; a free
// reads the next and then the previous node to merge; a split scans the slot map from slot 0.
// One request at a time; the next word can be taken in the cycle after the result is accepted.
// Synchronous reset starts a slot map clearing pass; no word is taken in it.
module first_fit_heap_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [11:0] request_size,
  input  logic [10:0] offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [10:0] block_offset,
  output logic        offset_free,
  output logic [11:0] bytes_left
);
  ffha_pkg::ffha_cmd_t cmd;
  ffha_pkg::ffha_sts_t sts;
  logic clr_done;
  logic in_rdy_c;

  ffha_ctrl u_ctrl (
    .clk(clk), .rst(rst | !clr_done), .in_valid(in_valid), .in_ready(in_rdy_c),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd));

  assign in_ready = in_rdy_c & clr_done;

  ffha_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .clr_done(clr_done), .op(op), .request_size(request_size), .offset(offset),
    .status(status), .block_offset(block_offset), .offset_free(offset_free),
    .bytes_left(bytes_left));
endmodule

>>> rtl/ffha_checker.sv
// Port-level checker for the heap allocator, bound to the top level.
// No package dependencies.
module ffha_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [11:0] bytes_left
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bytes_left <= 12'd2048) else $error("bytes_left range");
endmodule

bind first_fit_heap_allocator ffha_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .status(status),
  .bytes_left(bytes_left));

>>> test/first_fit_heap_allocator_tb.sv
// Testbench for the first-fit heap allocator: directed and random request words
// checked against a scoreboard that models the block chain bit for bit.
// Depends on ffha_pkg and the first_fit_heap_allocator RTL.
`timescale 1ns / 100ps

typedef struct {
  ffha_pkg::status_t status;
  logic [10:0]       block_offset;
  logic              offset_free;
  logic [11:0]       bytes_left;
} heap_reply_t;

class heap_scoreboard;
  localparam int HEAP = 2048;
  localparam logic [11:0] NIL = 12'd2048;

  logic [10:0] blk_start [HEAP];
  logic [11:0] blk_size  [HEAP];
  logic        blk_free  [HEAP];
  logic [11:0] blk_next  [HEAP];
  logic        slot_busy [HEAP];
  logic [11:0] bytes_free;
  heap_reply_t replies_due[$];
  logic [10:0] live_starts[$];
  int errors;

  function new();
    for (int i = 0; i < HEAP; i++) begin
      blk_start[i] = '0;
      blk_size[i]  = '0;
      blk_free[i]  = 1'b0;
      blk_next[i]  = '0;
      slot_busy[i] = 1'b0;
    end
    blk_size[0]  = NIL;
    blk_free[0]  = 1'b1;
    blk_next[0]  = NIL;
    slot_busy[0] = 1'b1;
    bytes_free   = 12'd2048;
    errors       = 0;
  endfunction

  function automatic int pending();
    return replies_due.size();
  endfunction

  function automatic bit covers(logic [11:0] n, logic [10:0] off);
    logic [11:0] s;
    s = {1'b0, blk_start[n]};
    return (s <= {1'b0, off}) && (({1'b0, off} - s) < blk_size[n]);
  endfunction

  // Walk the chain; prev returns the predecessor or NIL.
  function automatic logic [11:0] locate(logic [10:0] off, output logic [11:0] prev);
    logic [11:0] cur;
    logic [11:0] back;
    cur  = 12'd0;
    back = NIL;
    prev = NIL;
    for (int k = 0; k < HEAP && cur < NIL; k++) begin
      if (covers(cur, off)) begin
        prev = back;
        return cur;
      end
      back = cur;
      cur  = blk_next[cur];
    end
    return NIL;
  endfunction

  function automatic ffha_pkg::status_t take_block(logic [11:0] size,
                                                   output logic [10:0] where);
    logic [11:0] cur;
    logic [11:0] spare;
    logic [11:0] taken;
    logic [11:0] s;
    where = '0;
    if (size == 0 || size > bytes_free) return ffha_pkg::ST_BAD_SIZE;
    cur = 12'd0;
    for (int k = 0; k < HEAP && cur < NIL; k++) begin
      if (blk_free[cur] && blk_size[cur] >= size) begin
        spare = blk_size[cur] - size;
        taken = size;
        if (spare != 0) begin
          s = NIL;
          for (int i = 0; i < HEAP; i++)
            if (!slot_busy[i] && s == NIL) s = i[11:0];
          if (s < NIL) begin
            blk_start[s] = 11'(blk_start[cur] + size);
            blk_size[s]  = spare;
            blk_free[s]  = 1'b1;
            blk_next[s]  = blk_next[cur];
            slot_busy[s] = 1'b1;
            blk_next[cur] = s;
            blk_size[cur] = size;
          end else begin
            taken = blk_size[cur];
          end
        end
        blk_free[cur] = 1'b0;
        bytes_free = bytes_free - ((taken <= bytes_free) ? taken : bytes_free);
        where = blk_start[cur];
        return ffha_pkg::ST_OK;
      end
      cur = blk_next[cur];
    end
    return ffha_pkg::ST_NO_FIT;
  endfunction

  function automatic ffha_pkg::status_t release_block(logic [10:0] off);
    logic [11:0] prev;
    logic [11:0] cur;
    logic [11:0] nx;
    logic [12:0] sum;
    cur = locate(off, prev);
    if (cur >= NIL) return ffha_pkg::ST_OK;
    if (blk_free[cur]) return ffha_pkg::ST_DBL_FREE;
    foreach (live_starts[i])
      if (live_starts[i] == blk_start[cur]) begin
        live_starts.delete(i);
        break;
      end
    blk_free[cur] = 1'b1;
    sum = bytes_free + blk_size[cur];
    bytes_free = (sum > 13'd2048) ? 12'd2048 : sum[11:0];
    nx = blk_next[cur];
    if (nx < NIL && blk_free[nx]) begin
      blk_size[cur] = blk_size[cur] + blk_size[nx];
      blk_next[cur] = blk_next[nx];
      slot_busy[nx] = 1'b0;
    end
    if (prev < NIL && blk_free[prev]) begin
      blk_size[prev] = blk_size[prev] + blk_size[cur];
      blk_next[prev] = blk_next[cur];
      slot_busy[cur] = 1'b0;
    end
    return ffha_pkg::ST_OK;
  endfunction

  function automatic void note_request(ffha_pkg::op_t op, logic [11:0] size,
                                       logic [10:0] off);
    heap_reply_t r;
    logic [11:0] prev;
    logic [11:0] cur;
    r.status = ffha_pkg::ST_OK;
    r.block_offset = '0;
    r.offset_free = 1'b0;
    case (op)
      ffha_pkg::OP_ALLOC: begin
        r.status = take_block(size, r.block_offset);
        if (r.status == ffha_pkg::ST_OK) live_starts.push_back(r.block_offset);
      end
      ffha_pkg::OP_FREE: r.status = release_block(off);
      ffha_pkg::OP_QUERY: begin
        cur = locate(off, prev);
        r.offset_free = (cur < NIL) ? blk_free[cur] : 1'b0;
      end
      default: ;
    endcase
    r.bytes_left = bytes_free;
    replies_due.push_back(r);
  endfunction

  task report(string field, int got, int want);
    $display("ERROR %0t: %s got %0d expected %0d", $time, field, got, want);
    errors++;
  endtask

  task check_reply(logic [1:0] st, logic [10:0] bo, logic of, logic [11:0] bl);
    heap_reply_t w;
    if (replies_due.size() == 0) begin
      report("unexpected word, status", st, 0);
      return;
    end
    w = replies_due.pop_front();
    if (st !== w.status)       report("status", st, w.status);
    if (bo !== w.block_offset) report("block_offset", bo, w.block_offset);
    if (of !== w.offset_free)  report("offset_free", of, w.offset_free);
    if (bl !== w.bytes_left)   report("bytes_left", bl, w.bytes_left);
  endtask
endclass

module first_fit_heap_allocator_tb;
  localparam int WATCHDOG_LIMIT = 400000;
  localparam int LONG_HOLD = 3000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  op;
  logic [11:0] request_size;
  logic [10:0] offset;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [10:0] block_offset;
  logic        offset_free;
  logic [11:0] bytes_left;

  heap_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int hold_left;
  int quiet_cycles;

  first_fit_heap_allocator i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .request_size(request_size), .offset(offset),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .block_offset(block_offset),
    .offset_free(offset_free), .bytes_left(bytes_left)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Monitor both channels and the watchdog at every edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_request(ffha_pkg::op_t'(op), request_size, offset);
      if (out_valid && out_ready)
        sb.check_reply(status, block_offset, offset_free, bytes_left);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_req && hold_left == 0) begin
        hold_left = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task send_word(ffha_pkg::op_t o, logic [11:0] size, logic [10:0] off);
    op <= o;
    request_size <= size;
    offset <= off;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task drain();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task send_random();
    int r;
    logic [10:0] off;
    r = $urandom_range(99);
    off = 11'($urandom);
    if (sb.live_starts.size() != 0 && $urandom_range(99) < 80)
      off = 11'(sb.live_starts[$urandom_range(sb.live_starts.size() - 1)] +
                $urandom_range(0, 3));
    if (r < 45) begin
      if ($urandom_range(99) < 90)
        send_word(ffha_pkg::OP_ALLOC, 12'($urandom_range(1, 96)), 11'($urandom));
      else
        send_word(ffha_pkg::OP_ALLOC, 12'($urandom_range(0, 2048)), 11'($urandom));
    end else if (r < 80) begin
      send_word(ffha_pkg::OP_FREE, 12'($urandom), off);
    end else if (r < 97) begin
      send_word(ffha_pkg::OP_QUERY, 12'($urandom), off);
    end else begin
      send_word(ffha_pkg::OP_NONE, 12'($urandom), 11'($urandom));
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    op = ffha_pkg::OP_NONE;
    request_size = '0;
    offset = '0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    hold_left = 0;
    quiet_cycles = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: bad sizes, exact fit of the whole heap, inner free, double free.
    send_word(ffha_pkg::OP_ALLOC, 12'd0, 11'd0);
    send_word(ffha_pkg::OP_ALLOC, 12'd2048, 11'd0);
    send_word(ffha_pkg::OP_QUERY, 12'd0, 11'd2047);
    send_word(ffha_pkg::OP_ALLOC, 12'd1, 11'd0);
    send_word(ffha_pkg::OP_FREE, 12'd0, 11'd5);
    send_word(ffha_pkg::OP_FREE, 12'd0, 11'd0);
    send_word(ffha_pkg::OP_FREE, 12'd0, 11'd0);
    // Fragment the heap so that enough bytes remain but no block fits.
    send_word(ffha_pkg::OP_ALLOC, 12'd1000, 11'd0);
    send_word(ffha_pkg::OP_ALLOC, 12'd1000, 11'd0);
    send_word(ffha_pkg::OP_ALLOC, 12'd48, 11'd0);
    send_word(ffha_pkg::OP_ALLOC, 12'd1, 11'd0);
    send_word(ffha_pkg::OP_FREE, 12'hfff, 11'd10);
    send_word(ffha_pkg::OP_FREE, 12'd0, 11'd2047);
    send_word(ffha_pkg::OP_ALLOC, 12'd1040, 11'h7ff);
    send_word(ffha_pkg::OP_QUERY, 12'd0, 11'd1500);
    send_word(ffha_pkg::OP_QUERY, 12'd0, 11'd2010);
    send_word(ffha_pkg::OP_FREE, 12'd0, 11'd1999);
    send_word(ffha_pkg::OP_QUERY, 12'd0, 11'd1024);
    send_word(ffha_pkg::OP_NONE, 12'hfff, 11'h7ff);
    send_word(ffha_pkg::OP_ALLOC, 12'd2048, 11'd0);
    send_word(ffha_pkg::OP_FREE, 12'd0, 11'd0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      // Hold the receiver off while requests keep coming, to back up the input.
      if (ph == 0) hold_req = 1'b1;
      for (int n = 0; n < 30; n++) send_random();
      drain();
    end

    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/ffha_pkg.sv
rtl/ffha_ram.sv
rtl/ffha_ctrl.sv
rtl/ffha_dp.sv
rtl/first_fit_heap_allocator.sv
rtl/ffha_checker.sv
test/first_fit_heap_allocator_tb.sv
